FILE: src/sobpt_pkg.sv
// ----------------------------------------------------------------------------
// sobpt_pkg: shared types and constants for the Sobol point unit
// Field widths, the cell data word and the direction table, which is built
// from the fixed primitive polynomials when the design is elaborated.
// ----------------------------------------------------------------------------
package sobpt_pkg;

  localparam int DIMENSIONS    = 7;
  localparam int FRACTION_BITS = 32;
  localparam int DIM_W         = 3;
  localparam int INDEX_W       = 64;
  localparam int DIM_IDX_W     = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  // degree and inner coefficients (bit j-1 is a_j) of each polynomial
  localparam int POLY_DEGREE [DIMENSIONS] = '{0, 1, 2, 3, 4, 5, 6};
  localparam int POLY_INNER  [DIMENSIONS] = '{0, 0, 1, 1, 1, 2, 1};

  typedef logic [DIMENSIONS-1:0][FRACTION_BITS-1:0] dir_col_t;
  typedef dir_col_t [FRACTION_BITS-1:0]             dir_table_t;

  // one slot of the cell chain
  typedef struct packed {
    logic                     valid;
    logic                     bad;
    logic [DIM_W-1:0]         dim;
    logic [FRACTION_BITS-1:0] gray;
    logic [FRACTION_BITS-1:0] acc;
  } cell_data_t;

  // Bratley-Fox recurrence, all initial m = 1; tbl[k-1][d] holds v_k of d
  function automatic dir_table_t build_dir_table();
    dir_table_t  tbl;
    logic [63:0] m [0:FRACTION_BITS];
    logic [63:0] mk;
    int          s;
    tbl = '0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      for (int k = 0; k <= FRACTION_BITS; k++) begin
        m[k] = 64'd0;
      end
      s = POLY_DEGREE[d];
      for (int k = 1; k <= FRACTION_BITS; k++) begin
        if (s == 0 || k <= s) begin
          mk = 64'd1;
        end else begin
          mk = m[k-s] ^ (m[k-s] << s);
          for (int j = 1; j < s; j++) begin
            if (((POLY_INNER[d] >> (j - 1)) & 1) != 0) begin
              mk = mk ^ (m[k-j] << j);
            end
          end
        end
        m[k] = mk & 64'h0000_0000_FFFF_FFFF;
        tbl[k-1][d] = FRACTION_BITS'(m[k] << (FRACTION_BITS - k));
      end
    end
    return tbl;
  endfunction

  localparam dir_table_t DIR_TABLE = build_dir_table();

endpackage

FILE: src/sobpt_ifs.sv
// ----------------------------------------------------------------------------
// sobpt_ifs: channel interfaces of the Sobol point unit
// Valid/ready channels for the request (dimension, index) and the result.
// ----------------------------------------------------------------------------
interface sobpt_in_if import sobpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIM_W-1:0]   dimension;
  logic [INDEX_W-1:0] point_index;

  modport source (output valid, output dimension, output point_index, input ready);
  modport sink   (input valid, input dimension, input point_index, output ready);
endinterface

interface sobpt_out_if import sobpt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FRACTION_BITS-1:0] coordinate;
  logic                     bad_dimension;

  modport source (output valid, output coordinate, output bad_dimension, input ready);
  modport sink   (input valid, input coordinate, input bad_dimension, output ready);
endinterface

FILE: src/sobpt_cell.sv
// ----------------------------------------------------------------------------
// sobpt_cell: one Gray bit of the XOR reduction
// Consumes the low Gray bit, XORs in the direction word of the selected
// dimension for this bit position, and hands the slot to the next cell.
// ----------------------------------------------------------------------------
module sobpt_cell import sobpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  dir_col_t   dir_col,
  input  cell_data_t d_in,
  output cell_data_t d_out
);

  cell_data_t               data_r;
  logic [FRACTION_BITS-1:0] word;
  logic [FRACTION_BITS-1:0] acc_nxt;
  logic [FRACTION_BITS-1:0] gray_nxt;

  always_comb begin
    word     = d_in.bad ? '0 : dir_col[d_in.dim[DIM_IDX_W-1:0]];
    acc_nxt  = d_in.gray[0] ? (d_in.acc ^ word) : d_in.acc;
    gray_nxt = d_in.gray >> 1;
  end

  // only the valid bit is reset; the payload follows the enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.valid <= 1'b0;
    end else if (en) begin
      data_r.valid <= d_in.valid;
    end
    if (en) begin
      data_r.bad  <= d_in.bad;
      data_r.dim  <= d_in.dim;
      data_r.gray <= gray_nxt;
      data_r.acc  <= acc_nxt;
    end
  end

  assign d_out = data_r;

endmodule

FILE: src/sobol_sequence_point_unit.sv
// ----------------------------------------------------------------------------
// sobol_sequence_point_unit: Sobol coordinate from dimension and point index
// Gray-code Sobol generator over a chain of XOR cells.
// ----------------------------------------------------------------------------
// A request carries a dimension (0..6) and a 64-bit point index; the result
// is the coordinate as an unsigned 0.32 fraction. The Gray code of the index
// walks a chain of FRACTION_BITS (32) cells, one Gray bit per cell, and a new
// request is accepted every cycle unless a result waits untaken at the output.
// The last cell is the output register; while a result is not taken the whole
// chain holds. Dimension 7 returns bad_dimension = 1 with a zero coordinate.
// Direction words are constants, no fill after reset.
module sobol_sequence_point_unit import sobpt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sobpt_in_if.sink     in_ch,
  sobpt_out_if.source  out_ch
);

  cell_data_t chain [FRACTION_BITS+1];
  logic       advance;

  assign advance = !chain[FRACTION_BITS].valid || out_ch.ready;
  assign in_ch.ready = advance;

  assign chain[0] = '{valid: in_ch.valid,
                      bad:   (in_ch.dimension >= DIM_W'(DIMENSIONS)),
                      dim:   in_ch.dimension,
                      gray:  in_ch.point_index[FRACTION_BITS-1:0]
                           ^ in_ch.point_index[FRACTION_BITS:1],
                      acc:   '0};

  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_cell
    sobpt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .dir_col (DIR_TABLE[k]),
      .d_in    (chain[k]),
      .d_out   (chain[k+1])
    );
  end

  assign out_ch.valid         = chain[FRACTION_BITS].valid;
  assign out_ch.coordinate    = chain[FRACTION_BITS].acc;
  assign out_ch.bad_dimension = chain[FRACTION_BITS].bad;

  // out-of-range dimension never picks up a direction word
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_dimension |-> out_ch.coordinate == '0)
    else $error("bad dimension result with nonzero coordinate");

  // every Gray bit has been consumed by the time a slot leaves the chain
  a_gray_used: assert property (@(posedge clk) disable iff (!rst_n)
    chain[FRACTION_BITS].valid |-> chain[FRACTION_BITS].gray == '0)
    else $error("Gray bits left at chain end");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

FILE: tb/sobol_point_checker.sv
// ----------------------------------------------------------------------------
// sobol_point_checker: result predictor and scoreboard for the Sobol unit
// Watches both channels. Every accepted request is turned into the expected
// coordinate from a locally built direction table and queued; every accepted
// result is compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module sobol_point_checker import sobpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  sobpt_in_if   in_ch,
  sobpt_out_if  out_ch,
  output int    mismatch_count,
  output int    pending_points
);

  // tap masks of the primitive polynomials; the degree equals the dimension
  localparam int POLY_TAPS [DIMENSIONS] = '{0, 0, 1, 1, 1, 2, 1};

  typedef struct packed {
    logic [FRACTION_BITS-1:0] coordinate;
    logic                     bad_dimension;
  } sobol_result_t;

  logic [FRACTION_BITS-1:0] direction_words [DIMENSIONS][FRACTION_BITS];
  sobol_result_t            expected_points [$];
  sobol_result_t            oldest_point;

  // Bratley-Fox recurrence with every initial m = 1
  initial begin : fill_directions
    logic [63:0] m_val [FRACTION_BITS+1];
    logic [63:0] next_m;
    for (int d = 0; d < DIMENSIONS; d++) begin
      for (int k = 0; k <= FRACTION_BITS; k++) m_val[k] = 64'd0;
      for (int k = 1; k <= FRACTION_BITS; k++) begin
        if (d == 0 || k <= d) begin
          next_m = 64'd1;
        end else begin
          next_m = m_val[k-d] ^ (m_val[k-d] << d);
          for (int j = 1; j < d; j++) begin
            if (POLY_TAPS[d][j-1]) next_m = next_m ^ (m_val[k-j] << j);
          end
        end
        m_val[k] = next_m & 64'h0000_0000_FFFF_FFFF;
        direction_words[d][k-1] = FRACTION_BITS'(m_val[k] << (FRACTION_BITS - k));
      end
    end
  end

  function automatic sobol_result_t sobol_coordinate(logic [DIM_W-1:0]   dim,
                                                     logic [INDEX_W-1:0] idx);
    sobol_result_t     res;
    logic [INDEX_W-1:0] gray;
    res = '0;
    if (dim >= DIMENSIONS) begin
      res.bad_dimension = 1'b1;
      return res;
    end
    gray = idx ^ (idx >> 1);
    // gray bits at or above the fraction width drop out, so the sequence wraps
    for (int b = 0; b < FRACTION_BITS; b++) begin
      if (gray[b]) res.coordinate = res.coordinate ^ direction_words[dim][b];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual coordinate %h bad %b",
                   $time, out_ch.coordinate, out_ch.bad_dimension);
          mismatch_count++;
        end else begin
          oldest_point = expected_points.pop_front();
          if (out_ch.coordinate !== oldest_point.coordinate) begin
            $display("%0t: coordinate mismatch, expected %h actual %h",
                     $time, oldest_point.coordinate, out_ch.coordinate);
            mismatch_count++;
          end
          if (out_ch.bad_dimension !== oldest_point.bad_dimension) begin
            $display("%0t: bad_dimension mismatch, expected %b actual %b",
                     $time, oldest_point.bad_dimension, out_ch.bad_dimension);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_points.push_back(sobol_coordinate(in_ch.dimension, in_ch.point_index));
      end
    end
    pending_points <= expected_points.size();
  end

endmodule

FILE: tb/sobol_sequence_point_unit_test.sv
// ----------------------------------------------------------------------------
// sobol_sequence_point_unit_test: stimulus and verdict for the Sobol unit
// Directed edge cases, then batches of random, small, consecutive and
// wrap-crossing indices over all dimension codes, with random gaps on both
// sides, one long output stall and several input pauses that drain the chain.
// ----------------------------------------------------------------------------
module sobol_sequence_point_unit_test;
  import sobpt_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int BATCHES         = 18;
  localparam int BATCH_ITEMS     = 100;
  localparam int OUT_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 40;

  localparam logic [DIM_W-1:0] LAST_DIM         = DIM_W'(DIMENSIONS - 1);
  localparam logic [DIM_W-1:0] OUT_OF_RANGE_DIM = DIM_W'(DIMENSIONS);

  typedef enum int {IDX_RANDOM, IDX_SMALL, IDX_RUN, IDX_WRAP} index_mode_t;

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic hold_output = 1'b0;
  logic sender_fast = 1'b0;
  int   mismatch_count;
  int   pending_points;
  int   cycle_count  = 0;
  int   points_sent  = 0;
  int   drain_pauses = 0;

  always #5 clk = ~clk;

  sobpt_in_if  in_ch ();
  sobpt_out_if out_ch ();

  sobol_sequence_point_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sobol_point_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_points (pending_points)
  );

  // call at a rising edge; returns at the edge where the transaction is accepted
  task automatic offer_point(input logic [DIM_W-1:0] dim, input logic [INDEX_W-1:0] idx);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.dimension   <= dim;
    in_ch.point_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
  endtask

  initial begin : result_taker
    int   stall;
    logic fast;
    fast = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) fast = !fast;
      stall = fast ? 0 : $urandom_range(0, 8);
      if (hold_output) begin
        stall       = OUT_HOLD_CYCLES;
        hold_output = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_points);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    index_mode_t        mode;
    logic [DIM_W-1:0]   dim;
    logic [INDEX_W-1:0] idx;
    int                 items_left;
    int                 run_len;
    in_ch.valid       <= 1'b0;
    in_ch.dimension   <= '0;
    in_ch.point_index <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first direction word of every code, zero index, all ones,
    // high index bits that only reach the top Gray bit, bit patterns
    for (int d = 0; d <= OUT_OF_RANGE_DIM; d++) offer_point(DIM_W'(d), 64'd1);
    offer_point('0, '0);
    offer_point(LAST_DIM, '0);
    offer_point(OUT_OF_RANGE_DIM, '0);
    offer_point(LAST_DIM, '1);
    offer_point(DIM_W'(2), '1);
    offer_point(OUT_OF_RANGE_DIM, '1);
    offer_point(DIM_W'(5), 64'h0000_0001_0000_0000);
    offer_point(DIM_W'(4), 64'h0000_0000_FFFF_FFFF);
    offer_point(DIM_W'(1), 64'h8000_0000_0000_0000);
    offer_point(DIM_W'(3), 64'h5555_5555_5555_5555);
    offer_point(LAST_DIM, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_point('0, 64'h0000_0000_8000_0000);

    for (int batch = 0; batch < BATCHES; batch++) begin
      if (batch % 6 == 5) begin
        // let the chain drain completely before continuing
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_points == 0);
        @(posedge clk);
        drain_pauses++;
      end
      if (batch == 3) hold_output = 1'b1;
      sender_fast = (batch % 4 == 1);
      items_left  = BATCH_ITEMS;
      while (items_left > 0) begin
        mode    = index_mode_t'($urandom_range(0, 3));
        run_len = $urandom_range(1, 16);
        if (run_len > items_left) run_len = items_left;
        dim = DIM_W'($urandom_range(0, 7));
        case (mode)
          IDX_RUN:  idx = $urandom_range(0, 1) ? {$urandom, $urandom}
                                               : INDEX_W'($urandom_range(0, 4095));
          IDX_WRAP: idx = {$urandom, 32'hFFFF_FFF8};
          default:  idx = '0;
        endcase
        for (int i = 0; i < run_len; i++) begin
          case (mode)
            IDX_RANDOM: begin
              dim = DIM_W'($urandom_range(0, 7));
              idx = {$urandom, $urandom};
            end
            IDX_SMALL: begin
              dim = DIM_W'($urandom_range(0, 7));
              idx = INDEX_W'($urandom_range(0, 1023));
            end
            default: ;
          endcase
          offer_point(dim, idx);
          // consecutive indices, as a sampler walks the sequence
          if (mode == IDX_RUN || mode == IDX_WRAP) idx = idx + 1'b1;
        end
        items_left -= run_len;
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_points == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d points: all dimension codes incl. out of range, zero and edge",
             points_sent);
    $display("indices, consecutive runs across 2^32, one long output stall, %0d drains",
             drain_pauses);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sobpt_pkg.sv
src/sobpt_ifs.sv
src/sobpt_cell.sv
src/sobol_sequence_point_unit.sv
tb/sobol_point_checker.sv
tb/sobol_sequence_point_unit_test.sv
